// ----- hdl/assert_macros.svh -----
// Assertion macros used by the converter RTL (i2p_back).
// Depends on: the using module having clk and rst_n (active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define I2P_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define I2P_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/i2p_pkg.sv -----
// Types and codes for the infix to postfix converter.
// Depends on: nothing.
package i2p_pkg;

    localparam logic [2:0] TOK_OPERAND  = 3'd0;
    localparam logic [2:0] TOK_OPERATOR = 3'd1;
    localparam logic [2:0] TOK_LPAREN   = 3'd2;
    localparam logic [2:0] TOK_RPAREN   = 3'd3;
    localparam logic [2:0] TOK_END      = 3'd4;

    localparam logic [2:0] OPC_MINUS    = 3'd0;
    localparam logic [2:0] OPC_PLUS     = 3'd1;
    localparam logic [2:0] OPC_DIVIDE   = 3'd2;
    localparam logic [2:0] OPC_MULTIPLY = 3'd3;
    localparam logic [2:0] OPC_POWER    = 3'd4;
    localparam logic [2:0] PAREN_MARK   = 3'd5;

    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_RPAREN   = 2'd1;
    localparam logic [1:0] ERR_LPAREN   = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  oper_code;
        logic [31:0] operand_value;
    } token_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  out_oper;
        logic [31:0] out_value;
        logic [1:0]  err_code;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        CMD_OPERAND,
        CMD_OPERATOR,
        CMD_LPAREN,
        CMD_RPAREN,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  oper;
        logic [31:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } back_state_t;

endpackage

// ----- hdl/i2p_fifo.sv -----
// Two-entry register queue, generic over the entry type.
// Depends on: nothing.
module i2p_fifo #(
    parameter type T = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    T           slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       wr_fire;
    logic       rd_fire;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_fire;
        rd_ptr_next = rd_ptr_reg ^ rd_fire;
        cnt_next    = cnt_reg + {1'b0, wr_fire} - {1'b0, rd_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/i2p_front.sv -----
// Token intake: validates and classifies infix tokens into commands and queues them.
// Depends on: i2p_pkg, i2p_fifo.
module i2p_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  i2p_pkg::token_t token,
    output logic            cmd_valid,
    output i2p_pkg::cmd_t   cmd,
    input  logic            cmd_take
);

    logic          tok_ok;
    i2p_pkg::cmd_t cmd_in;
    logic          q_empty;

    always_comb
    begin
        tok_ok       = 1'b1;
        cmd_in.kind  = i2p_pkg::CMD_OPERAND;
        cmd_in.oper  = token.oper_code;
        cmd_in.value = token.operand_value;
        case (token.op)
            i2p_pkg::TOK_OPERAND:  cmd_in.kind = i2p_pkg::CMD_OPERAND;
            i2p_pkg::TOK_OPERATOR:
            begin
                cmd_in.kind = i2p_pkg::CMD_OPERATOR;
                tok_ok      = token.oper_code inside {[i2p_pkg::OPC_MINUS:i2p_pkg::OPC_POWER]};
            end
            i2p_pkg::TOK_LPAREN:   cmd_in.kind = i2p_pkg::CMD_LPAREN;
            i2p_pkg::TOK_RPAREN:   cmd_in.kind = i2p_pkg::CMD_RPAREN;
            i2p_pkg::TOK_END:      cmd_in.kind = i2p_pkg::CMD_END;
            default:               tok_ok      = 1'b0;
        endcase
    end

    // undefined tokens are accepted and dropped
    i2p_fifo #(
        .T (i2p_pkg::cmd_t)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && tok_ok),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_take),
        .rd_data (cmd),
        .empty   (q_empty)
    );

    assign cmd_valid = !q_empty;

endmodule

// ----- hdl/i2p_back.sv -----
// Command execution: operator stack in a memory, pop/push sequencing, result staging.
// Depends on: i2p_pkg, assert_macros.svh.
`include "assert_macros.svh"

module i2p_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  i2p_pkg::cmd_t    cmd,
    output logic             cmd_take,
    input  logic             res_full,
    output logic             res_wr,
    output i2p_pkg::result_t res_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    i2p_pkg::back_state_t state_reg;
    i2p_pkg::back_state_t state_next;
    i2p_pkg::cmd_t        cmd_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    i2p_pkg::result_t     pend_reg;
    i2p_pkg::result_t     pend_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic                 paren_reg;
    logic                 paren_next;

    logic [2:0]           stack_mem [STACK_DEPTH];
    logic [2:0]           top_reg;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [2:0]           push_data;

    logic                 has_top;
    logic                 is_full;
    logic                 top_paren;
    logic                 outranks;
    logic                 stall;
    logic                 finish_go;
    logic                 produce;
    i2p_pkg::result_t     prod_item;
    logic                 do_push;
    logic                 do_pop;
    logic                 done;

    assign has_top   = (count_reg != '0);
    assign is_full   = (count_reg == CW'(STACK_DEPTH));
    assign top_paren = (top_reg == i2p_pkg::PAREN_MARK);
    assign outranks  = (top_reg[2:1] > cmd_reg.oper[2:1])
                    || ((top_reg[2:1] == cmd_reg.oper[2:1])
                        && (cmd_reg.oper != i2p_pkg::OPC_POWER));
    assign stall     = pend_valid_reg && res_full;
    assign finish_go = (state_reg == i2p_pkg::ST_FINISH) && !stall;
    assign cmd_take  = cmd_valid && ((state_reg == i2p_pkg::ST_IDLE) || finish_go);
    assign push_data = (cmd_reg.kind == i2p_pkg::CMD_LPAREN) ? i2p_pkg::PAREN_MARK
                                                             : cmd_reg.oper;

    // one stack step per cycle in EXEC, unless the staged result is stalled by a full result queue
    always_comb
    begin
        produce   = 1'b0;
        prod_item = '0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        done      = 1'b0;
        if ((state_reg == i2p_pkg::ST_EXEC) && !stall)
        begin
            case (cmd_reg.kind)
                i2p_pkg::CMD_OPERAND:
                begin
                    produce             = 1'b1;
                    prod_item.out_kind  = i2p_pkg::KIND_OPERAND;
                    prod_item.out_value = cmd_reg.value;
                    done                = 1'b1;
                end
                i2p_pkg::CMD_OPERATOR:
                begin
                    if (has_top && !top_paren && outranks)
                    begin
                        produce            = 1'b1;
                        prod_item.out_kind = i2p_pkg::KIND_OPERATOR;
                        prod_item.out_oper = top_reg;
                        do_pop             = 1'b1;
                    end
                    else if (is_full)
                    begin
                        produce            = 1'b1;
                        prod_item.out_kind = i2p_pkg::KIND_ERROR;
                        prod_item.err_code = i2p_pkg::ERR_OVERFLOW;
                        done               = 1'b1;
                    end
                    else
                    begin
                        do_push = 1'b1;
                        done    = 1'b1;
                    end
                end
                i2p_pkg::CMD_LPAREN:
                begin
                    if (is_full)
                    begin
                        produce            = 1'b1;
                        prod_item.out_kind = i2p_pkg::KIND_ERROR;
                        prod_item.err_code = i2p_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        do_push = 1'b1;
                    end
                    done = 1'b1;
                end
                i2p_pkg::CMD_RPAREN:
                begin
                    if (!has_top)
                    begin
                        produce            = 1'b1;
                        prod_item.out_kind = i2p_pkg::KIND_ERROR;
                        prod_item.err_code = i2p_pkg::ERR_RPAREN;
                        done               = 1'b1;
                    end
                    else if (top_paren)
                    begin
                        do_pop = 1'b1;
                        done   = 1'b1;
                    end
                    else
                    begin
                        produce            = 1'b1;
                        prod_item.out_kind = i2p_pkg::KIND_OPERATOR;
                        prod_item.out_oper = top_reg;
                        do_pop             = 1'b1;
                    end
                end
                i2p_pkg::CMD_END:
                begin
                    if (!has_top)
                    begin
                        if (paren_reg)
                        begin
                            produce            = 1'b1;
                            prod_item.out_kind = i2p_pkg::KIND_ERROR;
                            prod_item.err_code = i2p_pkg::ERR_LPAREN;
                        end
                        done = 1'b1;
                    end
                    else
                    begin
                        do_pop = 1'b1;
                        if (!top_paren)
                        begin
                            produce            = 1'b1;
                            prod_item.out_kind = i2p_pkg::KIND_OPERATOR;
                            prod_item.out_oper = top_reg;
                        end
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2p_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = i2p_pkg::ST_EXEC;
                end
            end
            i2p_pkg::ST_EXEC:
            begin
                if (done)
                begin
                    state_next = i2p_pkg::ST_FINISH;
                end
            end
            i2p_pkg::ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = cmd_valid ? i2p_pkg::ST_EXEC : i2p_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = i2p_pkg::ST_IDLE;
            end
        endcase
    end

    // a staged result goes out when the next one arrives, or with last at finish
    always_comb
    begin
        res_wr          = pend_valid_reg && (produce || finish_go);
        res_data        = pend_reg;
        res_data.last   = (state_reg == i2p_pkg::ST_FINISH);
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (produce)
        begin
            pend_next       = prod_item;
            pend_valid_next = 1'b1;
        end
        else if (finish_go)
        begin
            pend_valid_next = 1'b0;
        end
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
        paren_next = paren_reg;
        if (cmd_take)
        begin
            paren_next = 1'b0;
        end
        else if ((cmd_reg.kind == i2p_pkg::CMD_END) && do_pop && top_paren)
        begin
            paren_next = 1'b1;
        end
        waddr = count_reg[AW-1:0];
        raddr = AW'(count_next - CW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= i2p_pkg::ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            paren_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            paren_reg      <= paren_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (cmd_take)
        begin
            cmd_reg <= cmd;
        end
    end

    // top of stack kept in the read register, with write bypass
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[waddr] <= push_data;
        end
        if (do_push && (waddr == raddr))
        begin
            top_reg <= push_data;
        end
        else
        begin
            top_reg <= stack_mem[raddr];
        end
    end

    `I2P_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(STACK_DEPTH))
    `I2P_ASSERT_NOW(a_push_room, do_push, !is_full && !do_pop)
    `I2P_ASSERT_NOW(a_res_room, res_wr, !res_full)
    `I2P_ASSERT_NOW(a_finish_last, finish_go && pend_valid_reg, res_wr && res_data.last)
    `I2P_ASSERT_NEXT(a_push_top, do_push, has_top && (top_reg == $past(push_data)))

endmodule

// ----- hdl/infix_to_postfix_converter.sv -----
// Shunting-yard infix to postfix converter, top level.
// Depends on: i2p_pkg, i2p_front, i2p_back, i2p_fifo.
//
// Input channel: token (op, oper_code, operand_value) is taken when push is
// high and full is low. Undefined token kinds and operators are taken and
// dropped. Result channel: result is valid while empty is low and is taken
// when pop is high. The final result produced by a token has last set;
// mismatched parens and stack overflow come out as error results.
// A two-entry command queue sits between intake and execution, and a
// two-entry result queue sits at the output.
// An operand passes through the command queue, cmd_reg, pend_reg and the
// result queue. Execution runs a token's stack steps in EXEC, one for an
// operand, push or paren plus one per stack entry popped, then passes
// through FINISH, where the next command is taken. The operator stack is
// a memory with one write and one registered read port.
// Reset empties both queues and the operator stack; no clearing pass.
// When the receiver stalls, the result queue fills, execution holds, the
// command queue fills, and full rises.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  i2p_pkg::token_t  token,
    output logic             empty,
    input  logic             pop,
    output i2p_pkg::result_t result
);

    logic             cmd_valid;
    i2p_pkg::cmd_t    cmd;
    logic             cmd_take;
    logic             res_full;
    logic             res_wr;
    i2p_pkg::result_t res_data;

    i2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .token     (token),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    i2p_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res_data  (res_data)
    );

    i2p_fifo #(
        .T (i2p_pkg::result_t)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ----- test/infix_to_postfix_converter_test.sv -----
// Testbench for infix_to_postfix_converter: sends infix token requests and checks the
// postfix result stream against a shunting-yard predictor kept inside the bench.
// Depends on: i2p_pkg, infix_to_postfix_converter.
module infix_to_postfix_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 32;
    localparam int SAW          = $clog2(STACK_DEPTH);
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             push  = 1'b0;
    logic             full;
    i2p_pkg::token_t  token = '0;
    logic             empty;
    logic             pop   = 1'b0;
    i2p_pkg::result_t result;

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned mismatch_count    = 0;
    int unsigned idle_cycles       = 0;
    int unsigned tokens_sent       = 0;

    logic [2:0]       operator_stack [STACK_DEPTH];
    int unsigned      operator_count = 0;
    i2p_pkg::result_t step_results [$];
    i2p_pkg::result_t expected_postfix [$];
    i2p_pkg::result_t next_expected;

    infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .token  (token),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [2:0] rand_code();
        return 3'($urandom_range(7));
    endfunction

    function automatic i2p_pkg::token_t make_token(logic [2:0] kind, logic [2:0] code,
                                                   logic [31:0] value);
        i2p_pkg::token_t t;
        t.op            = kind;
        t.oper_code     = code;
        t.operand_value = value;
        return t;
    endfunction

    function automatic void emit_postfix(logic [1:0] kind, logic [2:0] oper,
                                         logic [31:0] value, logic [1:0] err);
        i2p_pkg::result_t r;
        r.out_kind   = kind;
        r.out_oper   = oper;
        r.out_value  = value;
        r.err_code   = err;
        r.last       = 1'b0;
        step_results = {step_results, r};
    endfunction

    function automatic void push_operator_stack(logic [2:0] entry);
        if (operator_count >= STACK_DEPTH)
            emit_postfix(i2p_pkg::KIND_ERROR, '0, '0, i2p_pkg::ERR_OVERFLOW);
        else
        begin
            operator_stack[SAW'(operator_count)] = entry;
            operator_count++;
        end
    endfunction

    // precedence is the code with its low bit dropped
    function automatic void convert_token(i2p_pkg::token_t t);
        logic [2:0]       top;
        logic             settled;
        logic             paren_left;
        i2p_pkg::result_t r;
        step_results.delete();
        case (t.op)
            i2p_pkg::TOK_OPERAND:
                emit_postfix(i2p_pkg::KIND_OPERAND, '0, t.operand_value, i2p_pkg::ERR_NONE);
            i2p_pkg::TOK_OPERATOR:
                if (t.oper_code <= i2p_pkg::OPC_POWER)
                begin
                    settled = 1'b0;
                    while (operator_count > 0 && !settled)
                    begin
                        top = operator_stack[SAW'(operator_count - 1)];
                        if (top != i2p_pkg::PAREN_MARK &&
                            (top[2:1] > t.oper_code[2:1] ||
                             (top[2:1] == t.oper_code[2:1] &&
                              t.oper_code != i2p_pkg::OPC_POWER)))
                        begin
                            emit_postfix(i2p_pkg::KIND_OPERATOR, top, '0, i2p_pkg::ERR_NONE);
                            operator_count--;
                        end
                        else
                            settled = 1'b1;
                    end
                    push_operator_stack(t.oper_code);
                end
            i2p_pkg::TOK_LPAREN:
                push_operator_stack(i2p_pkg::PAREN_MARK);
            i2p_pkg::TOK_RPAREN:
            begin
                settled = 1'b0;
                while (operator_count > 0 && !settled)
                begin
                    operator_count--;
                    top = operator_stack[SAW'(operator_count)];
                    if (top == i2p_pkg::PAREN_MARK)
                        settled = 1'b1;
                    else
                        emit_postfix(i2p_pkg::KIND_OPERATOR, top, '0, i2p_pkg::ERR_NONE);
                end
                if (!settled)
                    emit_postfix(i2p_pkg::KIND_ERROR, '0, '0, i2p_pkg::ERR_RPAREN);
            end
            i2p_pkg::TOK_END:
            begin
                paren_left = 1'b0;
                while (operator_count > 0)
                begin
                    operator_count--;
                    top = operator_stack[SAW'(operator_count)];
                    if (top == i2p_pkg::PAREN_MARK)
                        paren_left = 1'b1;
                    else
                        emit_postfix(i2p_pkg::KIND_OPERATOR, top, '0, i2p_pkg::ERR_NONE);
                end
                if (paren_left)
                    emit_postfix(i2p_pkg::KIND_ERROR, '0, '0, i2p_pkg::ERR_LPAREN);
            end
            default:
                ;
        endcase
        foreach (step_results[i])
        begin
            r                = step_results[i];
            r.last           = (i == step_results.size() - 1);
            expected_postfix = {expected_postfix, r};
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_token(i2p_pkg::token_t t);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        push  <= 1'b1;
        token <= t;
        do
            @(posedge clk);
        while (full);
        convert_token(t);
        tokens_sent++;
        @(negedge clk);
    endtask

    function automatic void report_mismatch(string what, i2p_pkg::result_t want,
                                            i2p_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t %s: expected kind=%0d oper=%0d value=%h err=%0d last=%0b, ",
                     $realtime, what, want.out_kind, want.out_oper, want.out_value,
                     want.err_code, want.last,
                     "got kind=%0d oper=%0d value=%h err=%0d last=%0b",
                     got.out_kind, got.out_oper, got.out_value, got.err_code, got.last);
    endfunction

    always @(negedge clk)
        pop <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_postfix.size() == 0)
                report_mismatch("unexpected result", '0, result);
            else
            begin
                next_expected = expected_postfix.pop_front();
                if (result.out_kind  !== next_expected.out_kind  ||
                    result.out_oper  !== next_expected.out_oper  ||
                    result.out_value !== next_expected.out_value ||
                    result.err_code  !== next_expected.err_code  ||
                    result.last      !== next_expected.last)
                    report_mismatch("result mismatch", next_expected, result);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("infix_to_postfix_converter test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_operands();
        send_token(make_token(i2p_pkg::TOK_OPERAND, 3'd7, 32'h0000_0000));
        send_token(make_token(i2p_pkg::TOK_OPERAND, 3'd0, 32'hFFFF_FFFF));
        send_token(make_token(i2p_pkg::TOK_OPERAND, 3'd5, 32'h8000_0001));
        // end with an empty stack yields nothing
        send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
    endtask

    // a - b * c ^ d ^ e / f + g
    task automatic test_precedence();
        logic [2:0] chain [6];
        chain = '{i2p_pkg::OPC_MINUS, i2p_pkg::OPC_MULTIPLY, i2p_pkg::OPC_POWER,
                  i2p_pkg::OPC_POWER, i2p_pkg::OPC_DIVIDE, i2p_pkg::OPC_PLUS};
        foreach (chain[i])
        begin
            send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
            send_token(make_token(i2p_pkg::TOK_OPERATOR, chain[i], $urandom));
        end
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
    endtask

    task automatic test_parens();
        // ( a + b ) * c
        send_token(make_token(i2p_pkg::TOK_LPAREN, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERATOR, i2p_pkg::OPC_PLUS, $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_RPAREN, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERATOR, i2p_pkg::OPC_MULTIPLY, $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
        // unmatched right paren with an operator waiting, then on an empty stack
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERATOR, i2p_pkg::OPC_MINUS, $urandom));
        send_token(make_token(i2p_pkg::TOK_RPAREN, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_RPAREN, rand_code(), $urandom));
        // leftover left parens at end: ( a / ( b
        send_token(make_token(i2p_pkg::TOK_LPAREN, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERATOR, i2p_pkg::OPC_DIVIDE, $urandom));
        send_token(make_token(i2p_pkg::TOK_LPAREN, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
    endtask

    task automatic test_ignored_tokens();
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERATOR, i2p_pkg::OPC_PLUS, $urandom));
        for (int k = 5; k <= 7; k++)
        begin
            send_token(make_token(3'(k), rand_code(), $urandom));
            send_token(make_token(i2p_pkg::TOK_OPERATOR, 3'(k), $urandom));
        end
        send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
    endtask

    task automatic test_stack_overflow();
        send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
        repeat (STACK_DEPTH)
            send_token(make_token(i2p_pkg::TOK_LPAREN, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_LPAREN, rand_code(), $urandom));
        send_token(make_token(i2p_pkg::TOK_OPERATOR, i2p_pkg::OPC_MINUS, $urandom));
        send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
        // a full stack of powers, one too many, then a right paren flushes all of it
        repeat (STACK_DEPTH + 1)
            send_token(make_token(i2p_pkg::TOK_OPERATOR, i2p_pkg::OPC_POWER, $urandom));
        send_token(make_token(i2p_pkg::TOK_RPAREN, rand_code(), $urandom));
    endtask

    task automatic test_random_expressions(int unsigned n_items);
        int unsigned stop_at;
        int unsigned terms;
        int unsigned depth;
        stop_at = tokens_sent + n_items;
        while (tokens_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
                send_token(make_token(rand_code(), rand_code(), $urandom));
            else
            begin
                depth = 0;
                terms = $urandom_range(1, 8);
                for (int i = 0; i < terms; i++)
                begin
                    while (depth < 6 && $urandom_range(3) == 0)
                    begin
                        send_token(make_token(i2p_pkg::TOK_LPAREN, rand_code(), $urandom));
                        depth++;
                    end
                    send_token(make_token(i2p_pkg::TOK_OPERAND, rand_code(), $urandom));
                    while (depth > 0 && $urandom_range(2) == 0)
                    begin
                        send_token(make_token(i2p_pkg::TOK_RPAREN, rand_code(), $urandom));
                        depth--;
                    end
                    if (i != terms - 1)
                        send_token(make_token(i2p_pkg::TOK_OPERATOR,
                                              3'($urandom_range(i2p_pkg::OPC_POWER)),
                                              $urandom));
                end
                if ($urandom_range(7) != 0)
                    while (depth > 0)
                    begin
                        send_token(make_token(i2p_pkg::TOK_RPAREN, rand_code(), $urandom));
                        depth--;
                    end
                if ($urandom_range(11) == 0)
                    send_token(make_token(i2p_pkg::TOK_RPAREN, rand_code(), $urandom));
                if ($urandom_range(15) != 0)
                    send_token(make_token(i2p_pkg::TOK_END, rand_code(), $urandom));
            end
        end
    endtask

    initial
    begin
        sender_idle_pct   = 7;
        receiver_idle_pct = 84;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_operands();
        test_precedence();
        test_parens();
        test_ignored_tokens();
        test_stack_overflow();
        test_random_expressions(40);

        sender_idle_pct   = 84;
        receiver_idle_pct = 7;
        test_random_expressions(40);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_expressions(40);

        push <= 1'b0;
        while (expected_postfix.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && expected_postfix.size() == 0)
            $display("infix_to_postfix_converter test passed");
        else
            $display("infix_to_postfix_converter test failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/i2p_pkg.sv
hdl/i2p_fifo.sv
hdl/i2p_front.sv
hdl/i2p_back.sv
hdl/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_test.sv
